// ===== rtl/descriptive_statistics_engine_top_macros.svh =====
// Assertion macros used by the statistics engine checker.
`ifndef DESCRIPTIVE_STATISTICS_ENGINE_TOP_MACROS_SVH
`define DESCRIPTIVE_STATISTICS_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dse_pkg.sv =====
// Types, widths and constants of the descriptive statistics engine.
package dse_pkg;

  // field and accumulator widths
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 13;
  localparam int SUM_W    = 29;
  localparam int SQ_W     = 43;
  localparam int SQR_W    = 31;   // one sample squared
  localparam int SMAG_W   = 28;   // magnitude of the running sum
  localparam int NN_W     = 25;   // count squared
  localparam int PROD_W   = 56;   // shared unit operand width
  localparam int NUM_W    = 71;   // numerator / quotient shift register
  localparam int RAD_W    = 48;   // square root radicand
  localparam int ROOT_W   = 24;
  localparam int REM_W    = 25;
  localparam int STEP_W   = 7;
  localparam int MEAN_W   = 24;
  localparam int VAR_W    = 38;
  localparam int VAR_FRAC = 8;    // variance keeps 8 of the 16 fraction bits
  localparam int VAR_SHIFT  = 16; // d is scaled by 2^16 before the divide
  localparam int MEAN_SHIFT = 8;
  localparam int MEAN_NUM_W = SMAG_W + MEAN_SHIFT;

  // sequencer step counts
  localparam logic [STEP_W-1:0] STEPS_MUL_N   = STEP_W'(CNT_W);
  localparam logic [STEP_W-1:0] STEPS_MUL_S2  = STEP_W'(SMAG_W);
  localparam logic [STEP_W-1:0] STEPS_DIV_VAR = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] STEPS_SQRT    = STEP_W'(ROOT_W);
  localparam logic [STEP_W-1:0] STEPS_DIV_MEAN = STEP_W'(MEAN_NUM_W);

  localparam logic [CNT_W-1:0] MAX_COUNT = 13'd4096;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_MUL_NN,
    ST_MUL_NSQ,
    ST_MUL_S2,
    ST_SUB_D,
    ST_DIV_VAR,
    ST_SQRT,
    ST_DIV_MEAN,
    ST_MEAN_FIX,
    ST_PUBLISH
  } dse_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } dse_in_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0]   mean_value;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [VAR_W-1:0]           variance_value;
    logic [ROOT_W-1:0]          std_dev_value;
    logic [CNT_W-1:0]           sample_count;
    logic                       count_overflow;
  } dse_out_t;

endpackage

// ===== rtl/dse_alu.sv =====
// Shared adder/subtractor used by the arithmetic steps of the result sequencer.
module dse_alu import dse_pkg::*; (
  input  logic [PROD_W-1:0] a,
  input  logic [PROD_W-1:0] b,
  input  logic              sub,
  output logic [PROD_W:0]   res   // top bit: carry on add, borrow on subtract
);

  always_comb begin
    if (sub) begin
      res = {1'b0, a} - {1'b0, b};
    end else begin
      res = {1'b0, a} + {1'b0, b};
    end
  end

endmodule

// ===== rtl/descriptive_statistics_engine_top.sv =====
// Top level of the descriptive statistics engine: accumulators and result sequencer.
//
// Samples arrive on the in_ channel (valid/ready), one request per sample, the
// final sample of an array marked by last_sample. While an array streams in,
// in_ready stays high and one sample is taken every cycle.
// On the marked sample the block drops in_ready and runs its sequencer: one
// shared 56-bit adder/subtractor does shift-add multiplies (count squared,
// count times sum of squares, sum squared), a restoring divide for the
// variance, a digit-by-digit square root and a restoring divide for the mean.
// The result request appears on out_ once the sequencer has run its steps in
// order: drain, the three multiplies, the subtract, the variance divide, the
// square root, the mean divide, the mean fix-up and the publish step.
// The result sits in an output register; samples of the next array are taken
// while it waits. If the receiver stalls until the next array closes, the
// sequencer holds its finished result until the output register frees up.
// Samples beyond MAX_COUNT are discarded and reported in count_overflow.
// Reset (rst_n low, synchronous) clears the accumulators and the output valid.
module descriptive_statistics_engine_top import dse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dse_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dse_out_t out_data
);

  dse_state_t state_r, state_nxt;

  // accumulators
  logic signed [SUM_W-1:0]    acc_sum_r, acc_sum_nxt;
  logic [SQ_W-1:0]            acc_sq_r, acc_sq_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       drop_r, drop_nxt;
  logic [SQR_W-1:0]           sq_r, sq_nxt;
  logic                       sq_pend_r, sq_pend_nxt;

  // sequencer working registers
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SMAG_W-1:0]  smag_r, smag_nxt;
  logic [SMAG_W-1:0]  mlr_r, mlr_nxt;
  logic [SQ_W-1:0]    mcd_r, mcd_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [NN_W-1:0]    nn_r, nn_nxt;
  logic [PROD_W-1:0]  nsq_r, nsq_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [NN_W-1:0]    den_r, den_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [MEAN_W-1:0]  res_mean_r, res_mean_nxt;
  logic [VAR_W-1:0]   res_var_r, res_var_nxt;
  logic [ROOT_W-1:0]  res_sd_r, res_sd_nxt;

  // output register
  logic     out_valid_r, out_valid_nxt;
  dse_out_t out_r, out_nxt;

  // shared unit
  logic [PROD_W-1:0] alu_a, alu_b;
  logic              alu_sub;
  logic [PROD_W:0]   alu_res;
  logic              alu_ok;

  logic in_fire;

  assign in_ready  = (state_r == ST_ACCUM);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign alu_ok    = !alu_res[PROD_W];

  dse_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  // operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_DRAIN: begin
        // negate the sum for its magnitude
        alu_b   = {{(PROD_W-SUM_W){acc_sum_r[SUM_W-1]}}, acc_sum_r};
        alu_sub = 1'b1;
      end
      ST_MUL_NN, ST_MUL_NSQ, ST_MUL_S2: begin
        alu_a = {prod_r[PROD_W-2:0], 1'b0};
        alu_b = mlr_r[SMAG_W-1] ? {{(PROD_W-SQ_W){1'b0}}, mcd_r} : '0;
      end
      ST_SUB_D: begin
        alu_a   = nsq_r;
        alu_b   = prod_r;
        alu_sub = 1'b1;
      end
      ST_DIV_VAR, ST_DIV_MEAN: begin
        alu_a   = {{(PROD_W-REM_W-1){1'b0}}, rem_r, num_r[NUM_W-1]};
        alu_b   = {{(PROD_W-NN_W){1'b0}}, den_r};
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = {{(PROD_W-REM_W-2){1'b0}}, rem_r, num_r[NUM_W-1 -: 2]};
        alu_b   = {{(PROD_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
        alu_sub = 1'b1;
      end
      ST_MEAN_FIX: begin
        alu_b   = num_r[PROD_W-1:0];
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // next state, accumulators and sequencer datapath
  always_comb begin
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [NUM_W-1:0]             v16;
    logic [RAD_W-1:0]             rad;
    logic [MEAN_NUM_W-1:0]        q_mean;
    logic                         last_step;

    state_nxt     = state_r;
    acc_sum_nxt   = acc_sum_r;
    acc_sq_nxt    = acc_sq_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    sq_nxt        = sq_r;
    sq_pend_nxt   = 1'b0;
    step_nxt      = step_r;
    smag_nxt      = smag_r;
    mlr_nxt       = mlr_r;
    mcd_nxt       = mcd_r;
    prod_nxt      = prod_r;
    nn_nxt        = nn_r;
    nsq_nxt       = nsq_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    res_mean_nxt  = res_mean_r;
    res_var_nxt   = res_var_r;
    res_sd_nxt    = res_sd_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    sq_full   = in_data.sample * in_data.sample;
    v16       = '0;
    rad       = '0;
    q_mean    = num_r[MEAN_NUM_W-1:0];
    last_step = (step_r == STEP_W'(1));

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // square from the previous sample is registered and lands in the following cycle
    if (sq_pend_r) begin
      acc_sq_nxt = acc_sq_r + SQ_W'(sq_r);
    end

    unique case (state_r)
      ST_ACCUM: begin
        if (in_fire) begin
          if (cnt_r < MAX_COUNT) begin
            acc_sum_nxt = acc_sum_r + SUM_W'(in_data.sample);
            if (in_data.sample < min_r) min_nxt = in_data.sample;
            if (in_data.sample > max_r) max_nxt = in_data.sample;
            cnt_nxt     = cnt_r + 1'b1;
            sq_nxt      = sq_full[SQR_W-1:0];
            sq_pend_nxt = 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_sample) begin
            state_nxt = ST_DRAIN;
          end
        end
      end

      ST_DRAIN: begin
        smag_nxt  = acc_sum_r[SUM_W-1] ? alu_res[SMAG_W-1:0] : acc_sum_r[SMAG_W-1:0];
        mcd_nxt   = {{(SQ_W-CNT_W){1'b0}}, cnt_r};
        mlr_nxt   = {cnt_r, {(SMAG_W-CNT_W){1'b0}}};
        prod_nxt  = '0;
        step_nxt  = STEPS_MUL_N;
        state_nxt = ST_MUL_NN;
      end

      ST_MUL_NN, ST_MUL_NSQ, ST_MUL_S2: begin
        prod_nxt = alu_res[PROD_W-1:0];
        mlr_nxt  = {mlr_r[SMAG_W-2:0], 1'b0};
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          prod_nxt = '0;
          priority case (state_r)
            ST_MUL_NN: begin
              nn_nxt    = alu_res[NN_W-1:0];
              mcd_nxt   = acc_sq_r;
              mlr_nxt   = {cnt_r, {(SMAG_W-CNT_W){1'b0}}};
              step_nxt  = STEPS_MUL_N;
              state_nxt = ST_MUL_NSQ;
            end
            ST_MUL_NSQ: begin
              nsq_nxt   = alu_res[PROD_W-1:0];
              mcd_nxt   = {{(SQ_W-SMAG_W){1'b0}}, smag_r};
              mlr_nxt   = smag_r;
              step_nxt  = STEPS_MUL_S2;
              state_nxt = ST_MUL_S2;
            end
            default: begin
              prod_nxt  = alu_res[PROD_W-1:0];
              state_nxt = ST_SUB_D;
            end
          endcase
        end
      end

      ST_SUB_D: begin
        // d = n * sumsq - sum^2, scaled by 2^16 for the variance divide
        num_nxt   = {alu_res[NUM_W-VAR_SHIFT-1:0], {VAR_SHIFT{1'b0}}};
        rem_nxt   = '0;
        den_nxt   = nn_r;
        step_nxt  = STEPS_DIV_VAR;
        state_nxt = ST_DIV_VAR;
      end

      ST_DIV_VAR, ST_DIV_MEAN: begin
        num_nxt  = {num_r[NUM_W-2:0], alu_ok};
        rem_nxt  = alu_ok ? alu_res[REM_W-1:0] : {rem_r[REM_W-2:0], num_r[NUM_W-1]};
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          if (state_r == ST_DIV_VAR) begin
            v16 = {num_r[NUM_W-2:0], alu_ok};
            // saturate both results on an oversized quotient
            res_var_nxt = (|v16[NUM_W-1:VAR_W+VAR_FRAC]) ? '1 :
                          v16[VAR_W+VAR_FRAC-1:VAR_FRAC];
            rad         = (|v16[NUM_W-1:RAD_W]) ? '1 : v16[RAD_W-1:0];
            num_nxt     = {rad, {(NUM_W-RAD_W){1'b0}}};
            rem_nxt     = '0;
            root_nxt    = '0;
            step_nxt    = STEPS_SQRT;
            state_nxt   = ST_SQRT;
          end else begin
            state_nxt = ST_MEAN_FIX;
          end
        end
      end

      ST_SQRT: begin
        num_nxt  = {num_r[NUM_W-3:0], 2'b00};
        rem_nxt  = alu_ok ? alu_res[REM_W-1:0] : {rem_r[REM_W-3:0], num_r[NUM_W-1 -: 2]};
        root_nxt = {root_r[ROOT_W-2:0], alu_ok};
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          res_sd_nxt = {root_r[ROOT_W-2:0], alu_ok};
          // mean numerator |sum| * 256, left-aligned
          num_nxt    = {smag_r, {MEAN_SHIFT{1'b0}}, {(NUM_W-MEAN_NUM_W){1'b0}}};
          rem_nxt    = '0;
          den_nxt    = {{(NN_W-CNT_W){1'b0}}, cnt_r};
          step_nxt   = STEPS_DIV_MEAN;
          state_nxt  = ST_DIV_MEAN;
        end
      end

      ST_MEAN_FIX: begin
        // floor for negative sums: -(q + 1) = ~q when a remainder is left
        priority if (!acc_sum_r[SUM_W-1]) begin
          res_mean_nxt = q_mean[MEAN_W-1:0];
        end else if (rem_r != '0) begin
          res_mean_nxt = ~q_mean[MEAN_W-1:0];
        end else begin
          res_mean_nxt = alu_res[MEAN_W-1:0];
        end
        state_nxt = ST_PUBLISH;
      end

      ST_PUBLISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (cnt_r == '0) begin
            out_nxt = '0;
          end else begin
            out_nxt.mean_value     = res_mean_r;
            out_nxt.min_value      = min_r;
            out_nxt.max_value      = max_r;
            out_nxt.variance_value = res_var_r;
            out_nxt.std_dev_value  = res_sd_r;
            out_nxt.sample_count   = cnt_r;
          end
          out_nxt.count_overflow = drop_r;
          acc_sum_nxt = '0;
          acc_sq_nxt  = '0;
          min_nxt     = SAMPLE_MAX;
          max_nxt     = SAMPLE_MIN;
          cnt_nxt     = '0;
          drop_nxt    = 1'b0;
          state_nxt   = ST_ACCUM;
        end
      end

      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  // control and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      acc_sum_r   <= '0;
      acc_sq_r    <= '0;
      min_r       <= SAMPLE_MAX;
      max_r       <= SAMPLE_MIN;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      sq_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_sum_r   <= acc_sum_nxt;
      acc_sq_r    <= acc_sq_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      sq_pend_r   <= sq_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sq_r       <= sq_nxt;
    step_r     <= step_nxt;
    smag_r     <= smag_nxt;
    mlr_r      <= mlr_nxt;
    mcd_r      <= mcd_nxt;
    prod_r     <= prod_nxt;
    nn_r       <= nn_nxt;
    nsq_r      <= nsq_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    res_mean_r <= res_mean_nxt;
    res_var_r  <= res_var_nxt;
    res_sd_r   <= res_sd_nxt;
    out_r      <= out_nxt;
  end

endmodule

// ===== rtl/dse_checker.sv =====
// Port-level assertions for the statistics engine, bound to the top level.
`include "descriptive_statistics_engine_top_macros.svh"

module dse_checker import dse_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input dse_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input dse_out_t out_data
);

  // a stalled result keeps its request
  `DSE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed or dropped while stalled")

  // closing an array starts the sequencer, which takes no samples
  `DSE_ASSERT_NXT(a_busy_after_last, in_valid && in_ready && in_data.last_sample, !in_ready, "sample taken right after the last one")

  // extremes are ordered
  `DSE_ASSERT_IMP(a_min_le_max, out_valid, out_data.min_value <= out_data.max_value, "minimum above maximum")

  // samples are only dropped once the count is full
  `DSE_ASSERT_IMP(a_drop_full, out_valid && out_data.count_overflow, out_data.sample_count == MAX_COUNT, "overflow reported below the count limit")

  // count stays inside its range
  `DSE_ASSERT_IMP(a_count_range, out_valid, out_data.sample_count != '0 && out_data.sample_count <= MAX_COUNT, "sample count out of range")

endmodule

bind descriptive_statistics_engine_top dse_checker u_dse_checker (.*);

// ===== tb/descriptive_statistics_engine_top_tb.sv =====
// Self-checking testbench for the descriptive statistics engine top level.
module descriptive_statistics_engine_top_tb;
  import dse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int      CLK_HALF    = 4;
  localparam int      RAND_ITEMS  = 1840;
  localparam int      QUIET_ITEMS = 200;   // tail of the random part with no idling
  localparam int      DRAIN_WAIT  = 200;   // wait after the last expected result is checked
  localparam longint  TIMEOUT_NS  = 15_000_000;
  localparam longint unsigned VAR_SAT = 64'h3F_FFFF_FFFF;
  localparam longint unsigned SD_SAT  = 64'hFF_FFFF;

  typedef enum int {VAL_FULL, VAL_SMALL, VAL_EXTREME, VAL_CONST, VAL_NEAR} value_style_t;

  // one directed row: a sample repeated reps times, last flag on the final copy
  typedef struct {
    dse_in_t  item;
    int       reps;
    bit       typed;
    dse_out_t want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  dse_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dse_out_t out_data;

  // predictor state
  longint             acc_sum;
  longint unsigned    acc_sqsum;
  logic signed [15:0] acc_min;
  logic signed [15:0] acc_max;
  int unsigned        acc_count;
  bit                 acc_dropped;

  dse_out_t  stats_expected [$];
  dse_out_t  stats_want;
  stim_row_t dir_rows [$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  samples_sent = 0;
  int  arrays_sent  = 0;
  bit  quiet_tail   = 1'b0;
  bit  tx_calm      = 1'b0;
  bit  rx_calm      = 1'b0;
  int  rx_hold      = 0;
  int  rx_tick      = 0;

  descriptive_statistics_engine_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // back to the empty-array state
  task automatic clear_stats();
    acc_sum     = 0;
    acc_sqsum   = 0;
    acc_min     = SAMPLE_MAX;
    acc_max     = SAMPLE_MIN;
    acc_count   = 0;
    acc_dropped = 1'b0;
  endtask

  // bitwise integer square root, floored
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= root + probe) begin
        x    = x - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // fold one accepted request into the running statistics; closes on last_sample
  task automatic accumulate_sample(input dse_in_t d, output bit closed, output dse_out_t res);
    longint          x;
    longint unsigned n, nn, smag, mean_q, dev, quo, rem, v16, var_q, sd_q;
    x = $signed(d.sample);
    if (acc_count < MAX_COUNT) begin
      acc_sum   = acc_sum + x;
      acc_sqsum = acc_sqsum + longint'(x * x);
      if (x < acc_min) acc_min = d.sample;
      if (x > acc_max) acc_max = d.sample;
      acc_count++;
    end else begin
      acc_dropped = 1'b1;
    end
    closed = d.last_sample;
    res    = '0;
    if (closed) begin
      n = acc_count;
      if (n != 0) begin
        smag = (acc_sum < 0) ? -acc_sum : acc_sum;
        nn   = n * n;
        // mean floors toward minus infinity
        if (acc_sum < 0) mean_q = 64'd0 - ((smag * 256 + n - 1) / n);
        else             mean_q = (smag * 256) / n;
        dev   = n * acc_sqsum - smag * smag;
        quo   = dev / nn;
        rem   = dev % nn;
        v16   = quo * 65536 + (rem * 65536) / nn;
        var_q = v16 >> 8;
        if (var_q > VAR_SAT) var_q = VAR_SAT;
        sd_q  = floor_sqrt(v16);
        if (sd_q > SD_SAT) sd_q = SD_SAT;
        res.mean_value     = mean_q[23:0];
        res.min_value      = acc_min;
        res.max_value      = acc_max;
        res.variance_value = var_q[37:0];
        res.std_dev_value  = sd_q[23:0];
      end
      res.sample_count   = n[12:0];
      res.count_overflow = acc_dropped;
      clear_stats();
    end
  endtask

  // drive one request, with an optional idle burst ahead of it
  task automatic send_sample(input dse_in_t d, input bit typed, input dse_out_t typed_res);
    int       gap;
    bit       closed;
    dse_out_t res;
    if (!quiet_tail && !tx_calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    accumulate_sample(d, closed, res);
    if (closed) stats_expected.push_back(typed ? typed_res : res);
  endtask

  task automatic add_row(input logic signed [15:0] s, input bit last, input int reps,
                         input bit typed, input longint mean, input longint mn,
                         input longint mx, input longint var_v, input longint sd,
                         input int cnt, input bit ovf);
    stim_row_t row;
    row.item.sample           = s;
    row.item.last_sample      = last;
    row.reps                  = reps;
    row.typed                 = typed;
    row.want.mean_value       = mean[23:0];
    row.want.min_value        = mn[15:0];
    row.want.max_value        = mx[15:0];
    row.want.variance_value   = var_v[37:0];
    row.want.std_dev_value    = sd[23:0];
    row.want.sample_count     = cnt[12:0];
    row.want.count_overflow   = ovf;
    dir_rows.push_back(row);
  endtask

  function automatic logic signed [15:0] pick_value(value_style_t style,
                                                    logic signed [15:0] base);
    logic signed [15:0] v;
    case (style)
      VAL_SMALL: v = 16'($urandom_range(0, 16)) - 16'sd8;
      VAL_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = SAMPLE_MAX;
          1:       v = SAMPLE_MIN;
          2:       v = 16'sd0;
          3:       v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      VAL_CONST: v = base;
      VAL_NEAR:  v = base + 16'($urandom_range(0, 64)) - 16'sd32;
      default:   v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, fname, want, want, got, got);
      mismatches++;
    end
  endtask

  // receiver: random stall bursts, calm stretches, none at the end
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 150 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!quiet_tail && !rx_calm && $urandom_range(0, 2) == 0) begin
      rx_hold = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (stats_expected.size() == 0) begin
        $display("%0t: result with nothing expected, got 0x%0h", $time, out_data);
        mismatches++;
      end else begin
        stats_want = stats_expected.pop_front();
        results_seen++;
        check_field("mean_value", stats_want.mean_value, out_data.mean_value);
        check_field("min_value", stats_want.min_value, out_data.min_value);
        check_field("max_value", stats_want.max_value, out_data.max_value);
        check_field("variance_value", stats_want.variance_value, out_data.variance_value);
        check_field("std_dev_value", stats_want.std_dev_value, out_data.std_dev_value);
        check_field("sample_count", stats_want.sample_count, out_data.sample_count);
        check_field("count_overflow", stats_want.count_overflow, out_data.count_overflow);
      end
    end
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, stats_expected.size());
    $display("** descriptive_statistics_engine_top: FAILED **");
    $finish;
  end

  // main sequence
  initial begin
    dse_in_t            d;
    dse_out_t           none;
    value_style_t       style;
    logic signed [15:0] base;
    int                 len;
    int                 rand_left;
    int                 directed_samples;

    none     = '0;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    clear_stats();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table: sample, last, reps, typed, mean, min, max, var, sd, count, ovf
    add_row(16'sd0,      1, 1,    1, 0,        0,      0,      0, 0, 1, 0);
    add_row(SAMPLE_MAX,  1, 1,    1, 8388352,  32767,  32767,  0, 0, 1, 0);
    add_row(SAMPLE_MIN,  1, 1,    1, -8388608, -32768, -32768, 0, 0, 1, 0);
    // widest two-sample spread
    add_row(SAMPLE_MAX,  0, 1,    0, 0, 0, 0, 0, 0, 0, 0);
    add_row(SAMPLE_MIN,  1, 1,    1, -128, -32768, 32767, 274869518400, 8388480, 2, 0);
    add_row(-16'sd1,     0, 1,    0, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'sd1,      0, 1,    0, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'sh5555,   0, 1,    0, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'shAAAA,   1, 1,    0, 0, 0, 0, 0, 0, 0, 0);
    // negative mean that does not divide evenly
    add_row(16'sd1,      0, 1,    0, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'sd2,      0, 1,    0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-16'sd4,     1, 1,    0, 0, 0, 0, 0, 0, 0, 0);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        d             = dir_rows[r].item;
        d.last_sample = dir_rows[r].item.last_sample && (k == dir_rows[r].reps - 1);
        send_sample(d, dir_rows[r].typed, dir_rows[r].want);
      end
      if (dir_rows[r].item.last_sample) arrays_sent++;
    end
    directed_samples = samples_sent;

    // random arrays: mostly short, a few long, with assorted value styles
    rand_left = RAND_ITEMS;
    while (rand_left > 0) begin
      case ($urandom_range(0, 19))
        0, 1, 2: len = $urandom_range(25, 200);
        3:       len = $urandom_range(200, 600);
        default: len = $urandom_range(1, 24);
      endcase
      if (len > rand_left) len = rand_left;
      style   = value_style_t'($urandom_range(0, 4));
      base    = 16'($urandom);
      tx_calm = ($urandom_range(0, 3) == 0);
      if (rand_left <= QUIET_ITEMS) quiet_tail = 1'b1;
      for (int i = 0; i < len; i++) begin
        d.sample      = pick_value(style, base);
        d.last_sample = (i == len - 1);
        send_sample(d, 1'b0, none);
      end
      rand_left -= len;
      arrays_sent++;
    end

    @(negedge clk);
    in_valid <= 1'b0;

    while (stats_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d arrays and %0d samples (%0d directed), %0d results checked,",
             arrays_sent, samples_sent, directed_samples, results_seen);
    $display("including full-scale extremes, single-sample arrays and uneven negative means.");
    if (mismatches == 0) begin
      $display("** descriptive_statistics_engine_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** descriptive_statistics_engine_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dse_pkg.sv
rtl/dse_alu.sv
rtl/descriptive_statistics_engine_top.sv
rtl/dse_checker.sv
tb/descriptive_statistics_engine_top_tb.sv
